@@ hw/rtl/ttli_pkg.sv @@
// Package for the time table linear interpolator.
// It holds the operation and status codes, the controller states and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package ttli_pkg;

  localparam int TIME_W    = 32;
  localparam int VAL_W     = 16;
  localparam int RES_W     = 24;
  localparam int FRAC_W    = 8;
  localparam int NUM_W     = 56;
  localparam int QUO_W     = 24;
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = 5;
  localparam int IN_DATA_W = 48;
  localparam int IN_USER_W = 2;
  localparam int OUT_USER_W = 4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_SPAN  = 3'd2,
    ST_FULL  = 3'd3,
    ST_ORDER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RD_FIRST = 3'd0,
    RD_LAST  = 3'd1,
    RD_MID   = 3'd2,
    RD_IDX   = 3'd3,
    RD_PREV  = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_STATUS = 2'd0,
    RES_HIT    = 2'd1,
    RES_INTERP = 2'd2
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_CMP,
    S_Q_FIRST,
    S_Q_LAST,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_Q_NEXT,
    S_Q_PREV,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     clear_cnt;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_first;
    logic     wr_over;
    logic     wr_new;
    logic     srch_init;
    logic     srch_step;
    logic     cap_next;
    logic     cap_prev;
    logic     mul_start;
    logic     div_init;
    logic     div_step;
    logic     set_res;
    res_sel_t res_sel;
    status_t  res_code;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_full;
    logic key_eq_rd;
    logic key_lt_rd;
    logic key_gt_rd;
    logic srch_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/ttli_ctrl.sv @@
// Controller state machine of the time table linear interpolator.
// It sequences table updates, the search, the division and the result.
// Depends on ttli_pkg.
`timescale 1ns / 1ps

module ttli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  ttli_pkg::sts_t sts,
  output ttli_pkg::cmd_t cmd
);

  ttli_pkg::state_t state;
  ttli_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ttli_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ttli_pkg::S_DISPATCH;
        end
      end
      ttli_pkg::S_DISPATCH: begin
        unique case (sts.op)
          ttli_pkg::OP_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            cmd.set_res   = 1'b1;
            cmd.res_code  = ttli_pkg::ST_OK;
            state_next    = ttli_pkg::S_RESULT;
          end
          ttli_pkg::OP_APPEND: begin
            if (sts.cnt_zero) begin
              cmd.wr_first = 1'b1;
              cmd.set_res  = 1'b1;
              cmd.res_code = ttli_pkg::ST_OK;
              state_next   = ttli_pkg::S_RESULT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ttli_pkg::RD_LAST;
              state_next = ttli_pkg::S_APP_CMP;
            end
          end
          ttli_pkg::OP_QUERY: begin
            if (sts.cnt_zero) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ttli_pkg::ST_EMPTY;
              state_next   = ttli_pkg::S_RESULT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ttli_pkg::RD_FIRST;
              state_next = ttli_pkg::S_Q_FIRST;
            end
          end
          ttli_pkg::OP_NONE: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ttli_pkg::ST_OK;
            state_next   = ttli_pkg::S_RESULT;
          end
          default: begin
            state_next = ttli_pkg::S_IDLE;
          end
        endcase
      end
      ttli_pkg::S_APP_CMP: begin
        cmd.set_res = 1'b1;
        if (sts.key_eq_rd) begin
          cmd.wr_over  = 1'b1;
          cmd.res_code = ttli_pkg::ST_OK;
        end else if (sts.key_lt_rd) begin
          cmd.res_code = ttli_pkg::ST_ORDER;
        end else if (sts.cnt_full) begin
          cmd.res_code = ttli_pkg::ST_FULL;
        end else begin
          cmd.wr_new   = 1'b1;
          cmd.res_code = ttli_pkg::ST_OK;
        end
        state_next = ttli_pkg::S_RESULT;
      end
      ttli_pkg::S_Q_FIRST: begin
        if (sts.key_lt_rd) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ttli_pkg::ST_SPAN;
          state_next   = ttli_pkg::S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ttli_pkg::RD_LAST;
          state_next = ttli_pkg::S_Q_LAST;
        end
      end
      ttli_pkg::S_Q_LAST: begin
        if (sts.key_gt_rd) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ttli_pkg::ST_SPAN;
          state_next   = ttli_pkg::S_RESULT;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = ttli_pkg::S_SRCH_RD;
        end
      end
      ttli_pkg::S_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        if (sts.srch_done) begin
          cmd.rd_sel = ttli_pkg::RD_IDX;
          state_next = ttli_pkg::S_Q_NEXT;
        end else begin
          cmd.rd_sel = ttli_pkg::RD_MID;
          state_next = ttli_pkg::S_SRCH_CMP;
        end
      end
      ttli_pkg::S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = ttli_pkg::S_SRCH_RD;
      end
      ttli_pkg::S_Q_NEXT: begin
        cmd.cap_next = 1'b1;
        if (sts.key_eq_rd) begin
          cmd.set_res  = 1'b1;
          cmd.res_sel  = ttli_pkg::RES_HIT;
          cmd.res_code = ttli_pkg::ST_OK;
          state_next   = ttli_pkg::S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ttli_pkg::RD_PREV;
          state_next = ttli_pkg::S_Q_PREV;
        end
      end
      ttli_pkg::S_Q_PREV: begin
        cmd.cap_prev = 1'b1;
        state_next   = ttli_pkg::S_MUL;
      end
      ttli_pkg::S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = ttli_pkg::S_DIV_INIT;
      end
      ttli_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ttli_pkg::S_DIV;
      end
      ttli_pkg::S_DIV: begin
        if (sts.div_done) begin
          cmd.set_res  = 1'b1;
          cmd.res_sel  = ttli_pkg::RES_INTERP;
          cmd.res_code = ttli_pkg::ST_OK;
          state_next   = ttli_pkg::S_RESULT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ttli_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ttli_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ttli_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ttli_dp.sv @@
// Datapath of the time table linear interpolator: entry memories, entry
// count, search bounds, multiplier, restoring divider and output register.
// Depends on ttli_pkg.
`timescale 1ns / 1ps

module ttli_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ttli_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [ttli_pkg::IN_USER_W-1:0]      s_tuser,
  input  ttli_pkg::cmd_t                      cmd,
  output ttli_pkg::sts_t                      sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ttli_pkg::RES_W-1:0]          m_tdata,
  output logic [ttli_pkg::OUT_USER_W-1:0]     m_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = ttli_pkg::TIME_W;
  localparam int VW = ttli_pkg::VAL_W;
  localparam int QW = ttli_pkg::QUO_W;
  localparam int NW = ttli_pkg::NUM_W;
  localparam int RW = ttli_pkg::RES_W;
  localparam int FW = ttli_pkg::FRAC_W;
  localparam int DCW = ttli_pkg::DIV_CNT_W;

  logic [TW-1:0] times_mem [TABLE_DEPTH];
  logic [VW-1:0] values_mem [TABLE_DEPTH];

  ttli_pkg::op_t     op;
  logic [TW-1:0]     key;
  logic [VW-1:0]     sval;
  logic [CW-1:0]     count;
  logic [CW-1:0]     last_full;
  logic [AW-1:0]     last;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic [TW-1:0]     rd_time;
  logic [VW-1:0]     rd_val;
  logic [TW-1:0]     tn;
  logic [TW-1:0]     tp;
  logic [VW-1:0]     vn;
  logic [VW-1:0]     vp;
  logic [VW:0]       diff;
  logic [VW:0]       mag_full;
  logic [VW-1:0]     mag;
  logic [TW-1:0]     dt;
  logic [NW-1:0]     prod;
  logic [NW-1:0]     num;
  logic [TW-1:0]     den;
  logic              neg;
  logic [RW-1:0]     base;
  logic [TW-1:0]     rem;
  logic [QW-1:0]     nsh;
  logic [QW-1:0]     quo;
  logic [DCW-1:0]    div_cnt;
  logic [TW:0]       trial;
  logic [TW:0]       shifted;
  logic [RW-1:0]     step;
  logic [RW-1:0]     res_value;
  logic              res_hit;
  ttli_pkg::status_t res_status;

  assign last_full = count - CW'(1);
  assign last      = last_full[AW-1:0];
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[AW:1];

  always_comb begin
    unique case (cmd.rd_sel)
      ttli_pkg::RD_FIRST: rd_addr = '0;
      ttli_pkg::RD_LAST:  rd_addr = last;
      ttli_pkg::RD_MID:   rd_addr = mid;
      ttli_pkg::RD_IDX:   rd_addr = lo;
      ttli_pkg::RD_PREV:  rd_addr = lo - AW'(1);
      default:            rd_addr = lo;
    endcase
  end

  always_comb begin
    wr_en = cmd.wr_first | cmd.wr_over | cmd.wr_new;
    if (cmd.wr_first) begin
      wr_addr = '0;
    end else if (cmd.wr_over) begin
      wr_addr = last;
    end else begin
      wr_addr = count[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_mem[wr_addr]  <= key;
      values_mem[wr_addr] <= sval;
    end
    if (cmd.rd_en) begin
      rd_time <= times_mem[rd_addr];
      rd_val  <= values_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_cnt) begin
      count <= '0;
    end else if (cmd.wr_first) begin
      count <= CW'(1);
    end else if (cmd.wr_new) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= ttli_pkg::op_t'(s_tuser);
      key  <= s_tdata[TW-1:0];
      sval <= s_tdata[TW+VW-1:TW];
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= last;
    end else if (cmd.srch_step) begin
      if (rd_time < key) begin
        lo <= mid + AW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  assign diff     = {vn[VW-1], vn} - {vp[VW-1], vp};
  assign mag_full = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
  assign mag      = mag_full[VW-1:0];
  assign dt       = key - tp;
  assign prod     = NW'({mag, {FW{1'b0}}}) * NW'(dt);
  assign shifted  = {rem, nsh[QW-1]};
  assign trial    = shifted - {1'b0, den};
  assign step     = neg ? (~quo + RW'(1)) : quo;

  always_ff @(posedge clk) begin
    if (cmd.cap_next) begin
      tn <= rd_time;
      vn <= rd_val;
    end
    if (cmd.cap_prev) begin
      tp <= rd_time;
      vp <= rd_val;
    end
    if (cmd.mul_start) begin
      num  <= prod;
      den  <= tn - tp;
      neg  <= diff[VW];
      base <= {vp, {FW{1'b0}}};
    end
    if (cmd.div_init) begin
      rem     <= num[NW-1:QW];
      nsh     <= num[QW-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[TW]) begin
        rem <= trial[TW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= shifted[TW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
      nsh     <= {nsh[QW-2:0], 1'b0};
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      case (cmd.res_sel)
        ttli_pkg::RES_HIT: begin
          res_value <= {rd_val, {FW{1'b0}}};
          res_hit   <= 1'b1;
        end
        ttli_pkg::RES_INTERP: begin
          res_value <= base + step;
          res_hit   <= 1'b0;
        end
        default: begin
          res_value <= '0;
          res_hit   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_value;
      m_tuser <= {res_status, res_hit};
    end
  end

  always_comb begin
    sts.op        = op;
    sts.cnt_zero  = (count == '0);
    sts.cnt_full  = (count == CW'(TABLE_DEPTH));
    sts.key_eq_rd = (key == rd_time);
    sts.key_lt_rd = (key < rd_time);
    sts.key_gt_rd = (key > rd_time);
    sts.srch_done = (lo == hi);
    sts.div_done  = (div_cnt == DCW'(ttli_pkg::DIV_STEPS));
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

@@ hw/rtl/time_table_linear_interpolator.sv @@
// Time table linear interpolator: stream ports around a table of timed
// samples that is appended in ascending time order and queried with
// linear interpolation. Users should read each field as packed below.
//
// The slave channel takes one item: tuser holds the operation (clear,
// append, query) and tdata holds the time key and the signed sample value.
// The master channel returns exactly one item per input item.
// The block works on one item at a time; s_tready is high only while idle.
// Clear, unused codes, an append to an empty table and a query on an empty
// table go from dispatch straight to the result state; other appends first
// compare with the last entry, out-of-span queries with the first or last.
// An interpolating query runs the binary search over the N stored entries,
// which needs a read state and a compare state for each
// probe of the single table read port, and a one-bit-per-cycle divider
// that runs 24 steps. The block returns to idle as the result enters the
// output register, so the next item may arrive while that result waits.
// A stalled receiver holds the result and the block waits before loading
// the next one. Reset empties the table and drops any pending result;
// table contents are not cleared.
`timescale 1ns / 1ps

module time_table_linear_interpolator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // time_key [31:0], sample_value [47:32]
  input  logic [1:0]  s_tuser,  // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // interpolated_value [23:0]
  output logic [3:0]  m_tuser   // exact_hit [0], status [3:1]
);

  ttli_pkg::cmd_t cmd;
  ttli_pkg::sts_t sts;

  ttli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Item accepted while a previous item is still in work.");

  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[3:1] != ttli_pkg::ST_OK)) |-> (m_tdata == '0))
    else $error("Nonzero value returned with an error status.");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == ttli_pkg::ST_OK))
    else $error("Exact hit reported with an error status.");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("Result loaded over an item not yet taken.");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the time table linear interpolator.
// Drives clear, append and query items over the stream ports, predicts each result with a
// behavioral table model and checks every returned item. Depends on ttli_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = 1024;

  typedef struct packed {
    logic [23:0]       value;
    logic              hit;
    ttli_pkg::status_t status;
  } table_result_t;

  typedef struct packed {
    ttli_pkg::op_t op;
    logic [31:0]   key;
    logic [15:0]   sample;
    logic          typed;
    table_result_t want;
  } stim_row_t;

  localparam table_result_t RES_OK =
    '{value: 24'h0, hit: 1'b0, status: ttli_pkg::ST_OK};
  localparam table_result_t RES_EMPTY =
    '{value: 24'h0, hit: 1'b0, status: ttli_pkg::ST_EMPTY};
  localparam table_result_t RES_SPAN =
    '{value: 24'h0, hit: 1'b0, status: ttli_pkg::ST_SPAN};
  localparam table_result_t RES_ORDER =
    '{value: 24'h0, hit: 1'b0, status: ttli_pkg::ST_ORDER};
  localparam table_result_t RES_MIN_HIT =
    '{value: 24'h800000, hit: 1'b1, status: ttli_pkg::ST_OK};
  localparam table_result_t RES_MAX_HIT =
    '{value: 24'h7FFF00, hit: 1'b1, status: ttli_pkg::ST_OK};
  localparam table_result_t RES_SEVEN_HIT =
    '{value: 24'h000700, hit: 1'b1, status: ttli_pkg::ST_OK};

  localparam int NUM_DIR = 25;
  localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
    '{ttli_pkg::OP_QUERY,  32'h0000_0000, 16'h0000, 1'b1, RES_EMPTY},
    '{ttli_pkg::OP_NONE,   32'hFFFF_FFFF, 16'h8000, 1'b1, RES_OK},
    '{ttli_pkg::OP_APPEND, 32'h0000_0000, 16'h8000, 1'b1, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'h0000_0000, 16'h0000, 1'b1, RES_MIN_HIT},
    '{ttli_pkg::OP_QUERY,  32'h0000_0001, 16'h0000, 1'b1, RES_SPAN},
    '{ttli_pkg::OP_APPEND, 32'h0000_0000, 16'h7FFF, 1'b1, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'h0000_0000, 16'h0000, 1'b1, RES_MAX_HIT},
    '{ttli_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'h8000, 1'b1, RES_OK},
    '{ttli_pkg::OP_APPEND, 32'h0000_0005, 16'h0000, 1'b1, RES_ORDER},
    '{ttli_pkg::OP_QUERY,  32'h8000_0000, 16'h0000, 1'b0, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'hFFFF_FFFE, 16'h0000, 1'b0, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'hFFFF_FFFF, 16'h0000, 1'b1, RES_MIN_HIT},
    '{ttli_pkg::OP_QUERY,  32'h0000_0001, 16'h0000, 1'b0, RES_OK},
    '{ttli_pkg::OP_CLEAR,  32'h1234_5678, 16'hFFFF, 1'b1, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'h0000_0000, 16'h0000, 1'b1, RES_EMPTY},
    '{ttli_pkg::OP_APPEND, 32'd100,       16'd10,   1'b1, RES_OK},
    '{ttli_pkg::OP_APPEND, 32'd110,       16'hFFF6, 1'b1, RES_OK},
    '{ttli_pkg::OP_APPEND, 32'd111,       16'd5,    1'b1, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'd105,       16'h0000, 1'b0, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'd109,       16'h0000, 1'b0, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'd99,        16'h0000, 1'b1, RES_SPAN},
    '{ttli_pkg::OP_QUERY,  32'd112,       16'h0000, 1'b1, RES_SPAN},
    '{ttli_pkg::OP_NONE,   32'h0000_0000, 16'h0000, 1'b1, RES_OK},
    '{ttli_pkg::OP_APPEND, 32'd111,       16'd7,    1'b1, RES_OK},
    '{ttli_pkg::OP_QUERY,  32'd111,       16'h0000, 1'b1, RES_SEVEN_HIT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;

  logic          use_fixed = 1'b0;
  table_result_t fixed_result = '0;

  logic [31:0]        tbl_times [TABLE_DEPTH];
  logic signed [15:0] tbl_values [TABLE_DEPTH];
  int unsigned        tbl_count = 0;

  table_result_t pending_results [$];
  table_result_t model_result;
  table_result_t oldest;
  int unsigned   error_count = 0;
  int unsigned   sent_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  time_table_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic table_result_t apply_table_item(input ttli_pkg::op_t op,
                                                     input logic [31:0] key,
                                                     input logic signed [15:0] sample);
    table_result_t      r;
    int unsigned        lo, hi, mid;
    logic [31:0]        tp, tn;
    longint             vp, vn, diff, step;
    longint unsigned    mag, num, den, quo;
    r = RES_OK;
    case (op)
      ttli_pkg::OP_CLEAR: tbl_count = 0;
      ttli_pkg::OP_APPEND: begin
        if (tbl_count == 0) begin
          tbl_times[0] = key;
          tbl_values[0] = sample;
          tbl_count = 1;
        end else if (key == tbl_times[tbl_count - 1]) begin
          tbl_values[tbl_count - 1] = sample;
        end else if (key < tbl_times[tbl_count - 1]) begin
          r.status = ttli_pkg::ST_ORDER;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ttli_pkg::ST_FULL;
        end else begin
          tbl_times[tbl_count] = key;
          tbl_values[tbl_count] = sample;
          tbl_count++;
        end
      end
      ttli_pkg::OP_QUERY: begin
        if (tbl_count == 0) begin
          r.status = ttli_pkg::ST_EMPTY;
        end else if (key < tbl_times[0] || key > tbl_times[tbl_count - 1]) begin
          r.status = ttli_pkg::ST_SPAN;
        end else begin
          lo = 0;
          hi = tbl_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_times[mid] < key) lo = mid + 1;
            else hi = mid;
          end
          if (tbl_times[lo] == key) begin
            r.value = 24'(longint'(tbl_values[lo]) * 256);
            r.hit = 1'b1;
          end else begin
            tp = tbl_times[lo - 1];
            tn = tbl_times[lo];
            vp = tbl_values[lo - 1];
            vn = tbl_values[lo];
            diff = vn - vp;
            mag = (diff < 0) ? -diff : diff;
            num = mag * 64'd256 * 64'(key - tp);
            den = 64'(tn - tp);
            quo = num / den;
            step = (diff < 0) ? -longint'(quo) : longint'(quo);
            r.value = 24'(vp * 256 + step);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h/%h with no item outstanding", m_tdata, m_tuser));
        end else begin
          oldest = pending_results.pop_front();
          if (m_tdata !== oldest.value || m_tuser[0] !== oldest.hit ||
              m_tuser[3:1] !== oldest.status) begin
            report_mismatch($sformatf("got value %h hit %b status %0d, want %h %b %0d",
                                      m_tdata, m_tuser[0], m_tuser[3:1],
                                      oldest.value, oldest.hit, oldest.status));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        model_result = apply_table_item(ttli_pkg::op_t'(s_tuser), s_tdata[31:0],
                                        s_tdata[47:32]);
        pending_results.push_back(use_fixed ? fixed_result : model_result);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input ttli_pkg::op_t op, input logic [31:0] key,
                           input logic [15:0] sample, input logic typed,
                           input table_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sample, key};
    use_fixed <= typed;
    fixed_result <= want;
    do @(posedge clk); while (!s_tready);
    if (op != ttli_pkg::OP_NONE) sent_count++;
    @(negedge clk);
  endtask

  task automatic send(input ttli_pkg::op_t op, input logic [31:0] key,
                      input logic [15:0] sample);
    send_item(op, key, sample, 1'b0, RES_OK);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic build_entries(ref logic [31:0] built[$], input int unsigned n,
                               input bit fine_gaps);
    logic [31:0] last, gap, t;
    for (int unsigned i = 0; i < n; i++) begin
      if (built.size() == 0) begin
        if (fine_gaps) t = $urandom_range(0, 32'hF000_0000);
        else t = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom;
      end else begin
        last = built[$];
        case (fine_gaps ? 0 : $urandom_range(1, 3))
          0: gap = $urandom_range(1, 1000);
          1: gap = $urandom_range(1, 3);
          2: gap = $urandom_range(1, 5000);
          default: gap = ($urandom >> $urandom_range(0, 31)) | 32'd1;
        endcase
        if (gap > 32'hFFFF_FFFF - last) gap = 32'hFFFF_FFFF - last;
        if (gap == 0) return;
        t = last + gap;
      end
      send(ttli_pkg::OP_APPEND, t, rand_sample());
      built.push_back(t);
      if (!fine_gaps && $urandom_range(0, 14) == 0) send(ttli_pkg::OP_APPEND, t, rand_sample());
      if (!fine_gaps && $urandom_range(0, 14) == 0 && t > 0) begin
        send(ttli_pkg::OP_APPEND, $urandom_range(0, t - 1), rand_sample());
      end
    end
  endtask

  task automatic run_queries(ref logic [31:0] built[$], input int unsigned n);
    int unsigned i;
    logic [31:0] key, first, last;
    for (int unsigned q = 0; q < n; q++) begin
      key = $urandom;
      if (built.size() > 0) begin
        first = built[0];
        last = built[$];
        case ($urandom_range(0, 9))
          0, 1, 2: key = built[$urandom_range(0, built.size() - 1)];
          3, 4, 5, 6: begin
            if (built.size() >= 2) begin
              i = $urandom_range(0, built.size() - 2);
              key = built[i];
              if (built[i + 1] - built[i] > 1) begin
                key = built[i] + $urandom_range(1, built[i + 1] - built[i] - 1);
              end
            end
          end
          7: if (first > 0) key = $urandom_range(0, first - 1);
          8: if (last < 32'hFFFF_FFFF) key = $urandom_range(last + 1, 32'hFFFF_FFFF);
          default: ;
        endcase
      end
      send(ttli_pkg::OP_QUERY, key, 16'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    logic [31:0] built[$];
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        send(ttli_pkg::op_t'($urandom_range(0, 3)), $urandom, 16'($urandom));
      end else begin
        built.delete();
        send(ttli_pkg::OP_CLEAR, $urandom, 16'($urandom));
        build_entries(built, ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200)
                                                         : $urandom_range(1, 12), 1'b0);
        run_queries(built, $urandom_range(2, 10));
        if ($urandom_range(0, 2) == 0) begin
          build_entries(built, $urandom_range(1, 6), 1'b0);
          run_queries(built, $urandom_range(2, 8));
        end
      end
    end
  endtask

  initial begin
    logic [31:0] built[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 54;
    for (int i = 0; i < NUM_DIR; i++) begin
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].sample, DIR_ROWS[i].typed,
                DIR_ROWS[i].want);
    end

    // Fill the table to its last entry, then hit the full, overwrite and order cases.
    send(ttli_pkg::OP_CLEAR, 32'h0, 16'h0);
    build_entries(built, TABLE_DEPTH, 1'b1);
    send(ttli_pkg::OP_APPEND, built[$] + 32'd7, rand_sample());
    send(ttli_pkg::OP_APPEND, built[$], rand_sample());
    send(ttli_pkg::OP_APPEND, built[$] - 32'd1, rand_sample());
    run_queries(built, 8);
    run_random(200);

    send_idle_pct = 54;
    recv_idle_pct = 37;
    run_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(200);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
